@@ rtl/pfpp_pkg.sv @@
// ----------------------------------------------------------------------------
// pfpp_pkg: shared definitions for the prime-field point permuter
// Sequencer states, codes, control structures and constant lookups
// (prime map and smallest primitive roots) worked out at elaboration.
// ----------------------------------------------------------------------------
package pfpp_pkg;

	localparam int DEF_MAX_POINTS = 255;
	localparam int DEF_MAX_DIM    = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIZE,
		ST_FIND,
		ST_APPLY,
		ST_TORUS,
		ST_NORM,
		ST_INV,
		ST_SCALE,
		ST_ENC,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		GEN_TRANSV = 2'd0,
		GEN_CYCLE  = 2'd1,
		GEN_TORUS  = 2'd2,
		GEN_TRANSL = 2'd3
	} gen_sel_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_FIELD = 2'd1,
		STAT_ABSENT    = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_PRIME     = 2'd0,
		CFG_DIMENSION = 2'd1,
		CFG_PROJ_MODE = 2'd2
	} cfg_reg_t;

	// Control of the base-p enumeration counter.
	typedef struct packed {
		logic clear;
		logic step;
	} dctl_t;

	// Sieve of Eratosthenes over 0..255.
	function automatic logic [255:0] calc_prime_map();
		logic [255:0] m;
		int k;
		int j;
		m = '1;
		m[0] = 1'b0;
		m[1] = 1'b0;
		for (k = 2; k < 16; k++) begin
			for (j = k * k; j < 256; j += k) begin
				m[j] = 1'b0;
			end
		end
		return m;
	endfunction

	function automatic int mulmod_c(int x, int g, int p);
		int y;
		int r;
		y = 0;
		for (r = 0; r < g; r++) begin
			y += x;
			if (y >= p) begin
				y -= p;
			end
		end
		return y;
	endfunction

	function automatic logic [255:0][7:0] calc_roots(logic [255:0] pmap);
		logic [255:0][7:0] t;
		int p;
		int g;
		int x;
		int ord;
		logic found;
		for (p = 0; p < 256; p++) begin
			t[p] = 8'd1;
			found = 1'b0;
			if (pmap[p] && p > 2) begin
				for (g = 2; g < p; g++) begin
					if (!found) begin
						x = g;
						ord = 1;
						while (x != 1 && ord < p) begin
							x = mulmod_c(x, g, p);
							ord++;
						end
						if (x == 1 && ord == p - 1) begin
							t[p] = 8'(g);
							found = 1'b1;
						end
					end
				end
			end
		end
		return t;
	endfunction

	localparam logic [255:0]      PRIME_MAP = calc_prime_map();
	localparam logic [255:0][7:0] ROOT_TAB  = calc_roots(PRIME_MAP);

endpackage

@@ rtl/pfpp_addmod.sv @@
// ----------------------------------------------------------------------------
// pfpp_addmod: modular adder lane
// Adds two residues below the modulus and folds the sum back once.
// ----------------------------------------------------------------------------
module pfpp_addmod (
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic [7:0] modulus,
	output logic [7:0] sum
);
	logic [8:0] raw;

	assign raw = {1'b0, a} + {1'b0, b};
	assign sum = (raw >= {1'b0, modulus}) ? 8'(raw - {1'b0, modulus}) : raw[7:0];
endmodule

@@ rtl/pfpp_digit_counter.sv @@
// ----------------------------------------------------------------------------
// pfpp_digit_counter: base-p vector counter
// Walks the vectors of F_p^d in increasing encoding order, one per step,
// and flags whether the current vector is normalised.
// ----------------------------------------------------------------------------
module pfpp_digit_counter #(
	parameter int MAX_DIM = pfpp_pkg::DEF_MAX_DIM
) (
	input  logic                         clk,
	input  pfpp_pkg::dctl_t              ctl,
	input  logic [7:0]                   prime,
	input  logic [3:0]                   dim,
	output logic [MAX_DIM-1:0][7:0]      digits,
	output logic                         norm
);
	import pfpp_pkg::*;

	logic [MAX_DIM-1:0][7:0] digits_q;
	logic [MAX_DIM-1:0][7:0] next_digits;
	logic                    carry;
	logic                    seen;

	always_comb begin
		next_digits = digits_q;
		carry = 1'b1;
		for (int i = 0; i < MAX_DIM; i++) begin
			if (carry && i < int'(dim)) begin
				if (digits_q[i] == prime - 8'd1) begin
					next_digits[i] = '0;
				end else begin
					next_digits[i] = digits_q[i] + 8'd1;
					carry = 1'b0;
				end
			end
		end
	end

	// Normalised: the lowest nonzero digit equals one.
	always_comb begin
		norm = 1'b0;
		seen = 1'b0;
		for (int i = 0; i < MAX_DIM; i++) begin
			if (!seen && digits_q[i] != '0) begin
				seen = 1'b1;
				norm = (digits_q[i] == 8'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digits_q <= '0;
		end else if (ctl.step) begin
			digits_q <= next_digits;
		end
	end

	assign digits = digits_q;
endmodule

@@ rtl/prime_field_point_permuter_core.sv @@
// ----------------------------------------------------------------------------
// prime_field_point_permuter_core: one entry of an AGL / GL generator permutation
// Sequenced datapath over a shared bank of modular adder lanes.
// ----------------------------------------------------------------------------
// Each transaction takes a point index and a generator and returns the image
// point, or an error status with image 0. The block handles one transaction at
// a time and holds in_stall high until the result has been taken. The sequencer
// works step by step: it sizes the space, runs a base-p enumeration to locate
// the input vector, for the torus multiplies by the primitive root g through
// repeated addition, in projective mode scans for the inverse of the leading
// coordinate and scales by it, and enumerates again to encode and rank the
// image; an error is reported by the end of sizing at the latest.
// Configuration writes are taken at any time but must only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module prime_field_point_permuter_core #(
	parameter int MAX_POINTS = pfpp_pkg::DEF_MAX_POINTS,
	parameter int MAX_DIM    = pfpp_pkg::DEF_MAX_DIM
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] point_index,
	input  logic [1:0] generator_select,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] image_index,
	output logic [1:0] status
);
	import pfpp_pkg::*;

	localparam int IW = $clog2(MAX_DIM);

	// Configuration registers.
	logic [7:0] prime_q;
	logic [3:0] dim_q;
	logic       proj_q;

	seq_state_t state_q;
	seq_state_t state_d;

	// Transaction payload and working registers.
	logic [7:0]              pt_q;
	gen_sel_t                gen_q;
	logic [3:0]              size_cnt_q;
	logic [7:0]              npts_q;
	logic [7:0]              lines_q;
	logic [7:0]              k_q;
	logic [7:0]              cnt_q;
	logic [MAX_DIM-1:0][7:0] w_q;
	logic [MAX_DIM-1:0][7:0] acc_q;
	logic [7:0]              x_q;
	logic [7:0]              y_q;
	logic [7:0]              rep_q;
	logic [7:0]              img_q;
	status_t                 status_q;

	// Combinational helpers.
	logic [15:0]             prod;
	logic                    cfg_bad;
	logic                    gen_absent;
	logic [7:0]              limit;
	logic                    size_done;
	logic                    find_hit;
	logic                    enc_hit;
	logic [MAX_DIM-1:0][7:0] rotated;
	logic [7:0]              lead;
	dctl_t                   dctl;
	logic [MAX_DIM-1:0][7:0] digits;
	logic                    norm;
	logic [MAX_DIM-1:0][7:0] lane_a;
	logic [MAX_DIM-1:0][7:0] lane_b;
	logic [MAX_DIM-1:0][7:0] lane_s;

	// Configuration port: plain writes, indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= 8'd2;
			dim_q   <= 4'd1;
			proj_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PRIME:     prime_q <= cfg_wdata;
				CFG_DIMENSION: dim_q   <= cfg_wdata[3:0];
				CFG_PROJ_MODE: proj_q  <= cfg_wdata[0];
				default:       ;
			endcase
		end
	end

	// The field checks that need no iteration are done as the transaction is taken.
	assign cfg_bad = !PRIME_MAP[prime_q] || dim_q == 4'd0 || dim_q > 4'(MAX_DIM) ||
		(proj_q && dim_q < 4'd2);

	assign gen_absent = ((gen_q == GEN_TRANSV || gen_q == GEN_CYCLE) && dim_q < 4'd2) ||
		(gen_q == GEN_TORUS && prime_q < 8'd3) || (gen_q == GEN_TRANSL && proj_q);

	// The number of lines is 1 + p + ... + p^(d-1), accumulated while sizing.
	assign limit     = proj_q ? lines_q : npts_q;
	assign prod      = 16'(npts_q) * 16'(prime_q);
	assign size_done = (size_cnt_q == dim_q);
	assign find_hit  = proj_q ? (norm && cnt_q == pt_q) : (k_q == pt_q);
	assign enc_hit   = (digits == w_q);

	// Coordinate cycle: w[(i+1) mod d] = v[i].
	always_comb begin
		rotated = w_q;
		rotated[0] = w_q[IW'(dim_q - 4'd1)];
		for (int i = 1; i < MAX_DIM; i++) begin
			if (i < int'(dim_q)) begin
				rotated[i] = w_q[i-1];
			end
		end
	end

	// Lowest-index nonzero coordinate of the image.
	always_comb begin
		lead = '0;
		for (int i = MAX_DIM - 1; i >= 0; i--) begin
			if (w_q[i] != '0) begin
				lead = w_q[i];
			end
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = cfg_bad ? ST_DONE : ST_SIZE;
				end
			end
			ST_SIZE: begin
				if (size_done) begin
					state_d = (gen_absent || pt_q >= limit) ? ST_DONE : ST_FIND;
				end else if (prod > 16'(MAX_POINTS)) begin
					state_d = ST_DONE;
				end
			end
			ST_FIND: begin
				if (find_hit) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (gen_q == GEN_TORUS) begin
					state_d = ST_TORUS;
				end else begin
					state_d = proj_q ? ST_NORM : ST_ENC;
				end
			end
			ST_TORUS: begin
				if (rep_q == '0) begin
					state_d = proj_q ? ST_NORM : ST_ENC;
				end
			end
			ST_NORM:  state_d = ST_INV;
			ST_INV: begin
				if (acc_q[0] == 8'd1) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (rep_q == '0) begin
					state_d = ST_ENC;
				end
			end
			ST_ENC: begin
				if (enc_hit) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs: counter control and adder lane operands.
	always_comb begin
		dctl.clear = (state_q == ST_SIZE && state_d == ST_FIND) ||
			(state_q != ST_ENC && state_d == ST_ENC);
		dctl.step  = (state_q == ST_FIND && !find_hit) || (state_q == ST_ENC && !enc_hit);
		lane_a = acc_q;
		lane_b = w_q;
		case (state_q)
			ST_APPLY: begin
				lane_a[0] = w_q[0];
				lane_b[0] = (gen_q == GEN_TRANSV) ? w_q[1] : 8'd1;
			end
			ST_INV:   lane_b[0] = x_q;
			default:  ;
		endcase
	end

	pfpp_digit_counter #(
		.MAX_DIM (MAX_DIM)
	) u_counter (
		.clk    (clk),
		.ctl    (dctl),
		.prime  (prime_q),
		.dim    (dim_q),
		.digits (digits),
		.norm   (norm)
	);

	for (genvar l = 0; l < MAX_DIM; l++) begin : g_lane
		pfpp_addmod u_addmod (
			.a       (lane_a[l]),
			.b       (lane_b[l]),
			.modulus (prime_q),
			.sum     (lane_s[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (dctl.clear) begin
			k_q   <= '0;
			cnt_q <= '0;
		end
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pt_q       <= point_index;
					gen_q      <= gen_sel_t'(generator_select);
					npts_q     <= 8'd1;
					lines_q    <= '0;
					size_cnt_q <= '0;
					img_q      <= '0;
					status_q   <= STAT_BAD_FIELD;
				end
			end
			ST_SIZE: begin
				if (size_done) begin
					if (gen_absent) begin
						status_q <= STAT_ABSENT;
					end else begin
						status_q <= STAT_RANGE;
					end
				end else begin
					lines_q    <= lines_q + npts_q;
					npts_q     <= prod[7:0];
					size_cnt_q <= size_cnt_q + 4'd1;
				end
			end
			ST_FIND: begin
				if (find_hit) begin
					w_q <= digits;
				end else begin
					if (norm) begin
						cnt_q <= cnt_q + 8'd1;
					end
					k_q <= k_q + 8'd1;
				end
			end
			ST_APPLY: begin
				case (gen_q)
					GEN_CYCLE: w_q <= rotated;
					GEN_TORUS: begin
						acc_q[0] <= '0;
						rep_q    <= ROOT_TAB[prime_q];
					end
					default:   w_q[0] <= lane_s[0];
				endcase
			end
			ST_TORUS: begin
				if (rep_q == '0) begin
					w_q[0] <= acc_q[0];
				end else begin
					acc_q[0] <= lane_s[0];
					rep_q    <= rep_q - 8'd1;
				end
			end
			ST_NORM: begin
				x_q      <= lead;
				acc_q[0] <= lead;
				y_q      <= 8'd1;
			end
			ST_INV: begin
				if (acc_q[0] == 8'd1) begin
					rep_q <= y_q;
					acc_q <= '0;
				end else begin
					acc_q[0] <= lane_s[0];
					y_q      <= y_q + 8'd1;
				end
			end
			ST_SCALE: begin
				if (rep_q == '0) begin
					w_q <= acc_q;
				end else begin
					acc_q <= lane_s;
					rep_q <= rep_q - 8'd1;
				end
			end
			ST_ENC: begin
				if (enc_hit) begin
					img_q    <= proj_q ? cnt_q : k_q;
					status_q <= STAT_OK;
				end else begin
					if (norm) begin
						cnt_q <= cnt_q + 8'd1;
					end
					k_q <= k_q + 8'd1;
				end
			end
			default: ;
		endcase
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_DONE);
	assign image_index = img_q;
	assign status      = status_q;

	// An error result always carries image 0.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> image_index == 8'd0)
		else $error("error transaction with nonzero image");

	// A good image lies inside the numbering of the current mode.
	a_img_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_OK |-> image_index < (proj_q ? lines_q : npts_q))
		else $error("image index out of range");

	// The first image coordinate is reduced before the image is encoded.
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ENC |-> w_q[0] < prime_q)
		else $error("unreduced image coordinate");
endmodule
